>>> rtl/core/bdc_pkg.sv
package bdc_pkg;

  localparam logic [7:0] SAT_LIMIT = 8'd255;

  localparam logic [7:0] STABLE_TICKS_RESET  = 8'd3;
  localparam logic [7:0] CLICK_WINDOW_RESET  = 8'd30;
  localparam logic [1:0] CLICKS_NEEDED_RESET = 2'd2;

  typedef enum logic [1:0] {
    REG_STABLE_TICKS  = 2'd0,
    REG_CLICK_WINDOW  = 2'd1,
    REG_CLICKS_NEEDED = 2'd2,
    REG_NONE          = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic pin_level;
    logic charging;
  } in_item_t;

  typedef struct packed {
    logic       device_on;
    logic       turn_on_event;
    logic       turn_off_event;
    logic       raw_activity;
    logic [7:0] hold_ticks;
  } out_item_t;

  typedef struct packed {
    logic [7:0] stable_ticks;
    logic [7:0] click_window;
    logic [1:0] clicks_needed;
  } cfg_t;

  typedef struct packed {
    logic       accepted_level;
    logic       candidate_level;
    logic [7:0] stable_count;
    logic [7:0] hold_count;
    logic [7:0] gap_count;
    logic [1:0] click_count;
    logic       power_flag;
  } key_state_t;

endpackage

>>> rtl/core/bdc_step.sv
module bdc_step (
  input  bdc_pkg::key_state_t st,
  input  bdc_pkg::cfg_t       cfg,
  input  bdc_pkg::in_item_t   item,
  output bdc_pkg::key_state_t st_next,
  output bdc_pkg::out_item_t  result
);
  import bdc_pkg::*;

  logic       pressed;
  logic [1:0] need;
  logic [1:0] click_inc;
  logic       on_ev;
  logic       off_ev;

  assign pressed   = ~item.pin_level;
  assign click_inc = st.click_count + 2'd1;

  always_comb begin
    unique case (cfg.clicks_needed)
      2'd0:    need = 2'd1;
      2'd3:    need = 2'd2;
      default: need = cfg.clicks_needed;
    endcase
  end

  always_comb begin
    st_next = st;
    on_ev   = 1'b0;
    off_ev  = 1'b0;
    if (item.charging) begin
      st_next.accepted_level  = 1'b0;
      st_next.candidate_level = 1'b0;
      st_next.stable_count    = 8'd0;
      st_next.hold_count      = 8'd0;
      st_next.gap_count       = 8'd0;
      st_next.click_count     = 2'd0;
    end else if (pressed != st.candidate_level) begin
      st_next.candidate_level = pressed;
      st_next.stable_count    = 8'd0;
    end else if (st.stable_count < cfg.stable_ticks) begin
      st_next.stable_count = st.stable_count + 8'd1;
    end else if (st.accepted_level != pressed) begin
      if (pressed) begin
        st_next.hold_count  = 8'd0;
        st_next.click_count = click_inc;
      end else begin
        st_next.gap_count = 8'd0;
      end
      if (st_next.click_count == need) begin
        st_next.power_flag  = ~st.power_flag;
        on_ev               = ~st.power_flag;
        off_ev              = st.power_flag;
        st_next.click_count = 2'd0;
      end
      st_next.accepted_level = pressed;
    end else if (!pressed) begin
      if (st.click_count != 2'd0) begin
        if (st.gap_count >= cfg.click_window) begin
          st_next.click_count = 2'd0;
        end else if (st.gap_count < SAT_LIMIT) begin
          st_next.gap_count = st.gap_count + 8'd1;
        end
      end
    end else begin
      if (st.hold_count < SAT_LIMIT) begin
        st_next.hold_count = st.hold_count + 8'd1;
      end
    end
  end

  assign result.device_on      = st_next.power_flag;
  assign result.turn_on_event  = on_ev;
  assign result.turn_off_event = off_ev;
  assign result.raw_activity   = pressed & ~item.charging;
  assign result.hold_ticks     = st_next.hold_count;

endmodule

>>> rtl/core/button_debounce_click_power_toggle_unit.sv
// Each accepted item's result is registered into out_data, or into the skid entry while out_data is stalled.
// Throughput: one item per cycle while the skid entry is empty; key state updates in the accept cycle.
// A two-entry output buffer keeps in_ready high while one result waits.
// Reset (rst, synchronous): key state and power flag cleared, buffer empty,
// stable_ticks 3, click_window 30, clicks_needed 2.
module button_debounce_click_power_toggle_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bdc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bdc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import bdc_pkg::*;

  cfg_t       cfg;
  key_state_t st;
  key_state_t st_next;
  out_item_t  result;
  out_item_t  skid_data;
  logic       skid_valid;
  logic       in_fire;
  logic       out_fire;

  assign in_ready = ~skid_valid;
  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  bdc_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (in_data),
    .st_next (st_next),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stable_ticks  <= STABLE_TICKS_RESET;
      cfg.click_window  <= CLICK_WINDOW_RESET;
      cfg.clicks_needed <= CLICKS_NEEDED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STABLE_TICKS:  cfg.stable_ticks  <= cfg_data;
        REG_CLICK_WINDOW:  cfg.click_window  <= cfg_data;
        REG_CLICKS_NEEDED: cfg.clicks_needed <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> skid_valid)
    else $error("skid entry dropped while output stalled");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.turn_on_event && out_data.turn_off_event))
    else $error("on and off events in one item");

  a_on_event_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.turn_on_event) |-> out_data.device_on)
    else $error("on event without device on");

  a_charging_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.charging) |=> (st.click_count == 2'd0 && st.hold_count == 8'd0))
    else $error("charging item left key state");

endmodule
